[rtl/stiq_pkg.sv]
// shared types and constants for the sorted timer insert queue
package stiq_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int IDX_W       = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int OCC_W       = 5;
   localparam int DL_W        = 64;
   localparam int TAG_W       = 8;
   localparam int SEC_W       = 32;
   localparam int FREQ_W      = 32;
   localparam logic [FREQ_W-1:0] FREQ_RESET = 32'd62500000;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_ADD,
      ST_WALK,
      ST_PLACE,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic capture;
      logic mul;
      logic add;
      logic shift;
      logic place;
      logic respond;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
      logic less;
      logic pos_last;
   } status_type;

endpackage

[rtl/stiq_ctrl.sv]
// controller: sequences deadline computation, sorted walk and result handoff
module stiq_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  stiq_pkg::status_type status,
   output stiq_pkg::cmd_type    cmd
);

   stiq_pkg::state_type state_ff, state_in;
   logic                rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= stiq_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.respond) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         stiq_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = stiq_pkg::ST_MUL;
            end
         end
         stiq_pkg::ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = stiq_pkg::ST_ADD;
         end
         stiq_pkg::ST_ADD: begin
            cmd.add = 1'b1;
            if (status.full) begin
               state_in = stiq_pkg::ST_RESP;
            end else if (status.empty) begin
               state_in = stiq_pkg::ST_PLACE;
            end else begin
               state_in = stiq_pkg::ST_WALK;
            end
         end
         stiq_pkg::ST_WALK: begin
            if (status.less) begin
               cmd.shift = 1'b1;
               if (status.pos_last) begin
                  state_in = stiq_pkg::ST_PLACE;
               end
            end else begin
               state_in = stiq_pkg::ST_PLACE;
            end
         end
         stiq_pkg::ST_PLACE: begin
            cmd.place = 1'b1;
            state_in  = stiq_pkg::ST_RESP;
         end
         stiq_pkg::ST_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.respond = 1'b1;
               state_in    = stiq_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = stiq_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

   a_accept_starts_mul: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> state_ff == stiq_pkg::ST_MUL)
      else $error("accepted item did not start the multiply");

   a_respond_only_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.respond |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result register overwritten while stalled");

   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0(cmd))
      else $error("more than one datapath command");

endmodule

[rtl/stiq_dp.sv]
// datapath: deadline arithmetic, sorted entry memory, head and result registers
module stiq_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   input  logic [stiq_pkg::FREQ_W-1:0]   csr_counter_frequency,
   input  logic [stiq_pkg::SEC_W-1:0]    req_delay_seconds,
   input  logic [stiq_pkg::DL_W-1:0]     req_current_count,
   input  logic [stiq_pkg::TAG_W-1:0]    req_event_tag,
   input  stiq_pkg::cmd_type             cmd,
   output stiq_pkg::status_type          status,
   output logic [stiq_pkg::DL_W-1:0]     rsp_deadline,
   output logic                          rsp_new_head,
   output logic [stiq_pkg::DL_W-1:0]     rsp_head_deadline,
   output logic [stiq_pkg::TAG_W-1:0]    rsp_head_tag,
   output logic                          rsp_rejected,
   output logic [stiq_pkg::OCC_W-1:0]    rsp_occupancy
);

   logic [stiq_pkg::FREQ_W-1:0]  freq_ff;
   logic [stiq_pkg::SEC_W-1:0]   delay_ff;
   logic [stiq_pkg::DL_W-1:0]    now_ff;
   logic [stiq_pkg::TAG_W-1:0]   tag_ff;
   logic [stiq_pkg::DL_W-1:0]    prod_ff;
   logic [stiq_pkg::DL_W-1:0]    dl_ff;
   logic [stiq_pkg::IDX_W-1:0]   pos_ff;
   logic [stiq_pkg::CNT_W-1:0]   count_ff;
   logic [stiq_pkg::DL_W-1:0]    head_dl_ff;
   logic [stiq_pkg::TAG_W-1:0]   head_tag_ff;
   logic                         rej_ff;
   logic                         new_head_ff;

   logic [stiq_pkg::DL_W-1:0]    dl_mem [stiq_pkg::QUEUE_DEPTH];
   logic [stiq_pkg::TAG_W-1:0]   tag_mem [stiq_pkg::QUEUE_DEPTH];
   logic [stiq_pkg::DL_W-1:0]    rd_dl_ff;
   logic [stiq_pkg::TAG_W-1:0]   rd_tag_ff;
   logic [stiq_pkg::IDX_W-1:0]   rd_addr;
   logic                         wr_en;
   logic [stiq_pkg::DL_W-1:0]    wr_dl;
   logic [stiq_pkg::TAG_W-1:0]   wr_tag;

   logic [stiq_pkg::DL_W-1:0]    out_dl_ff;
   logic                         out_new_head_ff;
   logic [stiq_pkg::DL_W-1:0]    out_head_dl_ff;
   logic [stiq_pkg::TAG_W-1:0]   out_head_tag_ff;
   logic                         out_rej_ff;
   logic [stiq_pkg::CNT_W-1:0]   out_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         freq_ff <= stiq_pkg::FREQ_RESET;
      end else if (csr_valid) begin
         freq_ff <= csr_counter_frequency;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         delay_ff <= req_delay_seconds;
         now_ff   <= req_current_count;
         tag_ff   <= req_event_tag;
      end
      if (cmd.mul) begin
         prod_ff <= stiq_pkg::DL_W'(delay_ff) * stiq_pkg::DL_W'(freq_ff);
      end
      if (cmd.add) begin
         dl_ff <= prod_ff + now_ff;
      end
   end

   assign status.full     = (count_ff == stiq_pkg::CNT_W'(stiq_pkg::QUEUE_DEPTH));
   assign status.empty    = (count_ff == '0);
   assign status.less     = (dl_ff < rd_dl_ff);
   assign status.pos_last = (pos_ff == stiq_pkg::IDX_W'(1));

   // walk reads the entry below the one being moved
   assign rd_addr = cmd.shift ? (pos_ff - stiq_pkg::IDX_W'(2))
                              : stiq_pkg::IDX_W'(count_ff - stiq_pkg::CNT_W'(1));
   assign wr_en   = cmd.shift || cmd.place;
   assign wr_dl   = cmd.shift ? rd_dl_ff : dl_ff;
   assign wr_tag  = cmd.shift ? rd_tag_ff : tag_ff;

   always_ff @(posedge clock) begin
      rd_dl_ff  <= dl_mem[rd_addr];
      rd_tag_ff <= tag_mem[rd_addr];
      if (wr_en) begin
         dl_mem[pos_ff]  <= wr_dl;
         tag_mem[pos_ff] <= wr_tag;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.place) begin
         count_ff <= count_ff + stiq_pkg::CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.add) begin
         pos_ff      <= stiq_pkg::IDX_W'(count_ff);
         rej_ff      <= status.full;
         new_head_ff <= 1'b0;
      end else if (cmd.shift) begin
         pos_ff <= pos_ff - stiq_pkg::IDX_W'(1);
      end else if (cmd.place) begin
         new_head_ff <= (pos_ff == '0);
      end
      if (cmd.place && pos_ff == '0) begin
         head_dl_ff  <= dl_ff;
         head_tag_ff <= tag_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.respond) begin
         out_dl_ff       <= dl_ff;
         out_new_head_ff <= new_head_ff;
         out_head_dl_ff  <= head_dl_ff;
         out_head_tag_ff <= head_tag_ff;
         out_rej_ff      <= rej_ff;
         out_count_ff    <= count_ff;
      end
   end

   assign rsp_deadline      = out_dl_ff;
   assign rsp_new_head      = out_new_head_ff;
   assign rsp_head_deadline = out_head_dl_ff;
   assign rsp_head_tag      = out_head_tag_ff;
   assign rsp_rejected      = out_rej_ff;
   assign rsp_occupancy     = stiq_pkg::OCC_W'(out_count_ff);

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= stiq_pkg::CNT_W'(stiq_pkg::QUEUE_DEPTH))
      else $error("entry count beyond queue depth");

   a_shift_above_zero: assert property (@(posedge clock) disable iff (reset)
      cmd.shift |-> pos_ff != '0)
      else $error("shift past the head");

   a_place_not_full: assert property (@(posedge clock) disable iff (reset)
      cmd.place |-> !status.full)
      else $error("insert into a full queue");

   a_head_update: assert property (@(posedge clock) disable iff (reset)
      (cmd.place && pos_ff == '0) |=> head_dl_ff == $past(dl_ff))
      else $error("head not refreshed on insert at front");

endmodule

[rtl/sorted_timer_insert_queue.sv]
// Sorted timer insert queue: turns a delay in seconds into an absolute
// counter deadline (delay * counter_frequency + current_count, mod 2^64) and
// inserts it into a 16-entry queue kept in ascending deadline order, equal
// deadlines after existing ones. Every item gives one result with the
// deadline, whether it became the new head (load and enable the compare
// register), the head after the insert, a reject flag when the queue was full
// and the occupancy. An accepted item steps through capture, multiply, add,
// the walk and placement up to the result load. The walk moves the queued
// entries later than the new deadline (0 to 14) one at a time, since the
// entry memory has one read and one write port, and ends with one compare
// that finds an entry not later than the new deadline. An item that becomes
// the head moves every queued entry (0 to 15) and skips that compare. A
// rejected item goes from the add straight to the result load. The result
// sits in an output register, so the next item is taken while it waits.
// The frequency register may be written only while no item is in flight.
module sorted_timer_insert_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [stiq_pkg::FREQ_W-1:0]   csr_counter_frequency,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [stiq_pkg::SEC_W-1:0]    req_delay_seconds,
   input  logic [stiq_pkg::DL_W-1:0]     req_current_count,
   input  logic [stiq_pkg::TAG_W-1:0]    req_event_tag,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [stiq_pkg::DL_W-1:0]     rsp_deadline,
   output logic                          rsp_new_head,
   output logic [stiq_pkg::DL_W-1:0]     rsp_head_deadline,
   output logic [stiq_pkg::TAG_W-1:0]    rsp_head_tag,
   output logic                          rsp_rejected,
   output logic [stiq_pkg::OCC_W-1:0]    rsp_occupancy
);

   stiq_pkg::cmd_type    cmd;
   stiq_pkg::status_type status;

   assign csr_ready = 1'b1;

   stiq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   stiq_dp u_dp (
      .clock                 (clock),
      .reset                 (reset),
      .csr_valid             (csr_valid && csr_ready),
      .csr_counter_frequency (csr_counter_frequency),
      .req_delay_seconds     (req_delay_seconds),
      .req_current_count     (req_current_count),
      .req_event_tag         (req_event_tag),
      .cmd                   (cmd),
      .status                (status),
      .rsp_deadline          (rsp_deadline),
      .rsp_new_head          (rsp_new_head),
      .rsp_head_deadline     (rsp_head_deadline),
      .rsp_head_tag          (rsp_head_tag),
      .rsp_rejected          (rsp_rejected),
      .rsp_occupancy         (rsp_occupancy)
   );

endmodule
